// ===== sv/ramp_soak_setpoint_programmer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Ramp/soak setpoint programmer: assertion macros
// Shared assertion shorthands, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RAMP_SOAK_SETPOINT_PROGRAMMER_TOP_DEFINES_SVH
`define RAMP_SOAK_SETPOINT_PROGRAMMER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Ramp/soak setpoint programmer package
// Widths, state encodings, item structs and shared helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

  // Sizing
  localparam int MAX_STEPS = 16;
  localparam int VALUE_W   = 32;
  localparam int TICK_W    = 32;
  localparam int IDX_W     = $clog2(MAX_STEPS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int STEP_CAP  = (MAX_STEPS < 16) ? MAX_STEPS : 16;
  // Divider: signed difference needs one extra bit of magnitude
  localparam int DIFF_W    = VALUE_W + 1;
  localparam int DIV_CNT_W = $clog2(DIFF_W + 1);
  // Ramp product and the wide signed sum before saturation
  localparam int PROD_W    = TICK_W + VALUE_W;
  localparam int WIDE_W    = VALUE_W + 3;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_ENABLE  = 2'd2,
    CMD_DISABLE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PS_OFF      = 3'd0,
    PS_INIT     = 3'd1,
    PS_WAIT     = 3'd2,
    PS_SLAVE_EN = 3'd3,
    PS_RUN      = 3'd4,
    PS_NEXT     = 3'd5,
    PS_DISABLE  = 3'd6
  } prog_state_e;

  typedef enum logic [2:0] {
    SS_INIT = 3'd0,
    SS_RAMP = 3'd1,
    SS_HOLD = 3'd2,
    SS_DONE = 3'd3,
    SS_FAIL = 3'd4
  } step_state_e;

  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_DISABLE = 2'd2
  } req_e;

  // Sequencer states
  typedef enum logic [1:0] {
    CS_IDLE   = 2'd0,
    CS_EVAL   = 2'd1,
    CS_DIV    = 2'd2,
    CS_COMMIT = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]                command;
    logic [IDX_W-1:0]          step_slot;
    logic signed [VALUE_W-1:0] step_goal;
    logic [TICK_W-1:0]         reach_ticks;
    logic [TICK_W-1:0]         hold_ticks;
    logic signed [VALUE_W-1:0] sensor_value;
    logic                      sensor_ok;
    logic                      go_signal;
    logic                      slave_confirms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                program_state;
    logic [2:0]                step_state;
    logic [IDX_W-1:0]          active_step;
    logic signed [VALUE_W-1:0] setpoint;
    logic                      setpoint_send;
    logic [1:0]                slave_request;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic mul_load;
    logic commit;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_div;
    logic need_mul;
    logic div_busy;
  } dp_status_t;

  // Clamp a wide signed value to VALUE_W signed bits
  function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VALUE_W:0] top;
    top = v[WIDE_W-1:VALUE_W-1];
    if (top == '0 || top == '1) begin
      return v[VALUE_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/ramp_soak_setpoint_programmer_top.sv =====
// ----------------------------------------------------------------------------
// Ramp/soak setpoint programmer
// Runs a loaded table of ramp/hold steps and emits one result item per item.
//
// Input channel (in_valid_i/in_ready_o, in_item_i) carries commands: tick,
// load a step slot, enable or disable the program. Every accepted item yields
// exactly one result item on the output channel (out_valid_o/out_ready_i,
// out_item_o). The user is to write step_count through cfg_we_i/cfg_wdata_i
// only while idle; the block itself does not enforce this. Each item is
// captured, evaluated, passed through the serial slope divider when it is a
// tick that starts a ramp, and then committed to the output register. Only
// one item is in flight at a time. The divider retires one quotient bit per
// cycle over 33 bits. The result sits in an output register; the next item
// is accepted while it waits. If the receiver stalls, the following result
// waits in the datapath and no further item is taken until the output
// register frees up. Reset puts the program in off, the step in init,
// counters and step_count at zero; the step table is undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ramp_soak_setpoint_programmer_top_defines.svh"

module ramp_soak_setpoint_programmer_top import rsp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  out_item_t  res;
  out_item_t  out_item_q;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_take;
  logic       out_send;
  logic       out_req;

  assign out_free = !out_valid_q || out_ready_i;

  rsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  rsp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (res)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.commit) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  assign in_take  = in_valid_i && in_ready_o;
  assign out_send = out_valid_o && out_item_o.setpoint_send;
  assign out_req  = (out_item_o.slave_request != REQ_NONE);

  `RSP_ASSERT_NEXT(a_one_item_in_flight, in_take, !in_ready_o, "item taken while busy")
  `RSP_ASSERT_SAME(a_commit_needs_room, cmd.commit, out_free, "result overwritten")
  `RSP_ASSERT_SAME(a_send_xor_request, out_send, !out_req, "setpoint with slave request")

endmodule

`default_nettype wire

// ===== sv/rsp_div.sv =====
// ----------------------------------------------------------------------------
// Ramp/soak setpoint programmer: serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_div import rsp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIFF_W-1:0] dividend_i,
  input  wire logic [TICK_W-1:0] divisor_i,
  output logic                   busy_o,
  output logic [DIFF_W-1:0]      quot_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [TICK_W-1:0]    rem_q, rem_d;
  logic [DIFF_W-1:0]    quo_q, quo_d;
  logic [TICK_W-1:0]    dvs_q, dvs_d;
  logic [TICK_W:0]      trial;
  logic                 fits;

  // One restoring step: bring down the next dividend bit
  assign trial = {rem_q, quo_q[DIFF_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIFF_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? TICK_W'(trial - {1'b0, dvs_q}) : trial[TICK_W-1:0];
      quo_d = {quo_q[DIFF_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== sv/rsp_dpath.sv =====
// ----------------------------------------------------------------------------
// Ramp/soak setpoint programmer: datapath
// Step table, program/step state, slope division, ramp multiply and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_dpath import rsp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire in_item_t         in_item_i,
  input  wire ctrl_cmd_t        cmd_i,
  output dp_status_t            status_o,
  output out_item_t             res_o
);

  // Captured item and configuration
  in_item_t         in_q;
  logic [CNT_W-1:0] step_count_q;
  logic [CNT_W-1:0] eff_cnt;

  // Step table
  logic signed [VALUE_W-1:0] goal_tbl_q  [MAX_STEPS];
  logic [TICK_W-1:0]         reach_tbl_q [MAX_STEPS];
  logic [TICK_W-1:0]         hold_tbl_q  [MAX_STEPS];
  logic signed [VALUE_W-1:0] cur_goal;
  logic [TICK_W-1:0]         cur_reach;
  logic [TICK_W-1:0]         cur_hold;

  // Architectural state
  prog_state_e               prog_q, prog_d;
  step_state_e               step_q, step_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [TICK_W-1:0]         el_q, el_d;
  logic signed [VALUE_W-1:0] start_q, start_d;
  logic signed [VALUE_W-1:0] slope_q, slope_d;

  // Arithmetic
  logic                      div_neg_q;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_mag;
  logic                      div_busy;
  logic [DIFF_W-1:0]         quot;
  logic signed [WIDE_W-1:0]  quot_s;
  logic [VALUE_W-1:0]        slope_mag;
  logic [PROD_W-1:0]         prod_q;
  logic [VALUE_W:0]          prod_cap;
  logic signed [WIDE_W-1:0]  start_w;
  logic signed [WIDE_W-1:0]  prod_w;
  logic signed [VALUE_W-1:0] ramp_val;
  logic [TICK_W-1:0]         el_inc;
  logic                      is_tick;

  // Result pieces
  logic                      send;
  logic signed [VALUE_W-1:0] sp;
  req_e                      req;
  logic                      tbl_we;

  localparam logic [PROD_W-1:0] PROD_CAP = PROD_W'(1) << VALUE_W;

  assign eff_cnt   = (step_count_q > CNT_W'(STEP_CAP)) ? CNT_W'(STEP_CAP) : step_count_q;
  assign cur_goal  = goal_tbl_q[idx_q];
  assign cur_reach = reach_tbl_q[idx_q];
  assign cur_hold  = hold_tbl_q[idx_q];
  assign is_tick   = (cmd_e'(in_q.command) == CMD_TICK);
  assign el_inc    = (el_q == '1) ? el_q : el_q + TICK_W'(1);

  // Which long operations this item needs
  assign status_o.need_div = is_tick && (prog_q == PS_RUN) && (step_q == SS_INIT) &&
                             (cur_reach != '0) && in_q.sensor_ok;
  assign status_o.need_mul = is_tick && (prog_q == PS_RUN) && (step_q == SS_RAMP) &&
                             (el_q < cur_reach);
  assign status_o.div_busy = div_busy;

  // Slope division: |goal - sensor| / reach, sign applied afterwards
  assign diff     = DIFF_W'(cur_goal) - DIFF_W'(in_q.sensor_value);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;

  rsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (diff_mag),
    .divisor_i  (cur_reach),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign quot_s = div_neg_q ? -$signed(WIDE_W'(quot)) : $signed(WIDE_W'(quot));

  // Ramp value: start +/- min(elapsed * |slope|, 2^VALUE_W), saturated
  assign slope_mag = slope_q[VALUE_W-1] ? VALUE_W'(-slope_q) : slope_q;
  assign prod_cap  = (prod_q > PROD_CAP) ? {1'b1, {VALUE_W{1'b0}}} : prod_q[VALUE_W:0];
  assign start_w   = WIDE_W'(start_q);
  assign prod_w    = $signed(WIDE_W'(prod_cap));
  assign ramp_val  = sat_val(slope_q[VALUE_W-1] ? start_w - prod_w : start_w + prod_w);

  // Next architectural state for the captured item
  always_comb begin
    prog_d  = prog_q;
    step_d  = step_q;
    idx_d   = idx_q;
    el_d    = el_q;
    start_d = start_q;
    slope_d = slope_q;
    send    = 1'b0;
    sp      = '0;
    req     = REQ_NONE;
    tbl_we  = 1'b0;
    case (cmd_e'(in_q.command))
      CMD_LOAD:    tbl_we = 1'b1;
      CMD_ENABLE:  prog_d = PS_INIT;
      CMD_DISABLE: prog_d = PS_DISABLE;
      default: begin
        case (prog_q)
          PS_INIT: begin
            if (eff_cnt != '0) begin
              idx_d  = '0;
              step_d = SS_INIT;
              prog_d = PS_WAIT;
            end else begin
              prog_d = PS_OFF;
            end
          end
          PS_WAIT: begin
            if (in_q.go_signal) prog_d = PS_SLAVE_EN;
          end
          PS_SLAVE_EN: begin
            req = REQ_ENABLE;
            if (in_q.slave_confirms) prog_d = PS_RUN;
          end
          PS_RUN: begin
            // one tick of the current step
            case (step_q)
              SS_INIT: begin
                el_d = '0;
                if (cur_reach != '0) begin
                  if (!in_q.sensor_ok) begin
                    step_d = SS_FAIL;
                  end else begin
                    start_d = in_q.sensor_value;
                    slope_d = sat_val(quot_s);
                    step_d  = SS_RAMP;
                  end
                end else if (cur_hold != '0) begin
                  step_d = SS_HOLD;
                end else begin
                  step_d = SS_DONE;
                end
              end
              SS_RAMP: begin
                if (el_q >= cur_reach) begin
                  el_d   = '0;
                  step_d = (cur_hold != '0) ? SS_HOLD : SS_DONE;
                end else begin
                  sp   = ramp_val;
                  send = 1'b1;
                  el_d = el_inc;
                end
              end
              SS_HOLD: begin
                if (el_q >= cur_hold) begin
                  step_d = SS_DONE;
                end else begin
                  sp   = cur_goal;
                  send = 1'b1;
                  el_d = el_inc;
                end
              end
              SS_DONE, SS_FAIL: begin
              end
              default: step_d = SS_FAIL;
            endcase
            if (step_d == SS_DONE) begin
              prog_d = PS_NEXT;
            end else if (step_d == SS_FAIL) begin
              prog_d = PS_DISABLE;
            end
          end
          PS_NEXT: begin
            if ({1'b0, idx_q} + CNT_W'(1) >= eff_cnt) begin
              prog_d = PS_DISABLE;
            end else begin
              idx_d  = idx_q + IDX_W'(1);
              step_d = SS_INIT;
              prog_d = PS_RUN;
            end
          end
          PS_DISABLE: begin
            req = REQ_DISABLE;
            if (in_q.slave_confirms) prog_d = PS_OFF;
          end
          default: prog_d = PS_OFF;
        endcase
      end
    endcase
  end

  // Result item
  assign res_o.program_state = prog_d;
  assign res_o.step_state    = step_d;
  assign res_o.active_step   = idx_d;
  assign res_o.setpoint      = sp;
  assign res_o.setpoint_send = send;
  assign res_o.slave_request = req;

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= '0;
      prog_q       <= PS_OFF;
      step_q       <= SS_INIT;
      idx_q        <= '0;
      el_q         <= '0;
      start_q      <= '0;
      slope_q      <= '0;
    end else begin
      if (cfg_we_i) step_count_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        prog_q  <= prog_d;
        step_q  <= step_d;
        idx_q   <= idx_d;
        el_q    <= el_d;
        start_q <= start_d;
        slope_q <= slope_d;
      end
    end
  end

  // Item capture, sign of the division, ramp product
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture)   in_q      <= in_item_i;
    if (cmd_i.div_start) div_neg_q <= diff[DIFF_W-1];
    if (cmd_i.mul_load)  prod_q    <= el_q * slope_mag;
  end

  // Step table writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && tbl_we) begin
      goal_tbl_q[in_q.step_slot]  <= in_q.step_goal;
      reach_tbl_q[in_q.step_slot] <= in_q.reach_ticks;
      hold_tbl_q[in_q.step_slot]  <= in_q.hold_ticks;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ramp/soak setpoint programmer: sequencer
// Steps one item through capture, evaluation, division when needed, and commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_ctrl import rsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       out_free_i,
  input  wire dp_status_t status_i,
  output logic            in_ready_o,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_EVAL;
      end
      CS_EVAL: begin
        state_d = status_i.need_div ? CS_DIV : CS_COMMIT;
      end
      CS_DIV: begin
        if (!status_i.div_busy) state_d = CS_COMMIT;
      end
      CS_COMMIT: begin
        if (out_free_i) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.capture   = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.mul_load  = 1'b0;
    cmd_o.commit    = 1'b0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      CS_EVAL: begin
        cmd_o.div_start = status_i.need_div;
        cmd_o.mul_load  = status_i.need_mul;
      end
      CS_COMMIT: cmd_o.commit = out_free_i;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Ramp/soak setpoint programmer testbench
// Drives command items (loads, enables, disables and ticks) into the block
// and checks every result item against a cycle-free predictor of the program
// and step state machines, the slope division and the ramp arithmetic.
// Both channels idle at random. The receiver stalls once for a long stretch.
// The step count is rewritten between phases, while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rsp_pkg::*;

  localparam logic signed [VALUE_W-1:0] V_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] V_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF    = 200;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;

  ramp_soak_setpoint_programmer_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Items waiting to be offered, and results waiting to arrive
  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  out_item_t want_item;

  // Shadow of the programmer state
  logic [CNT_W-1:0]          step_count_reg;
  prog_state_e               prog_now;
  step_state_e               step_now;
  logic [IDX_W-1:0]          step_idx;
  logic [TICK_W-1:0]         elapsed;
  logic signed [VALUE_W-1:0] ramp_base;
  logic signed [VALUE_W-1:0] ramp_rate;
  logic signed [VALUE_W-1:0] goal_tab  [MAX_STEPS];
  logic [TICK_W-1:0]         reach_tab [MAX_STEPS];
  logic [TICK_W-1:0]         hold_tab  [MAX_STEPS];

  // Generator bookkeeping: slots ever loaded
  bit loaded [MAX_STEPS];

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_mismatch = 0;
  int n_loads = 0;
  int n_ticks = 0;
  int n_cfg = 0;
  int n_sends = 0;
  int n_step_fails = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  function automatic logic signed [VALUE_W-1:0] clamp_value(longint v);
    if (v > longint'(V_MAX)) return V_MAX;
    if (v < longint'(V_MIN)) return V_MIN;
    return v[VALUE_W-1:0];
  endfunction

  // Advance the shadow state by one item and return the result it causes
  function automatic out_item_t next_programmer_result(in_item_t it);
    out_item_t                 r;
    logic signed [VALUE_W-1:0] sp;
    logic signed [VALUE_W-1:0] goal;
    logic [TICK_W-1:0]         reach;
    logic [TICK_W-1:0]         hold;
    logic [CNT_W-1:0]          eff;
    req_e                      req;
    bit                        send;
    longint                    diff;
    longint                    prod;
    longint unsigned           mag;
    longint unsigned           pm;
    longint unsigned           cap;
    longint unsigned           e;
    sp   = '0;
    send = 1'b0;
    req  = REQ_NONE;
    eff  = (step_count_reg > STEP_CAP) ? CNT_W'(STEP_CAP) : step_count_reg;
    cap  = longint'(1) << VALUE_W;
    case (it.command)
      CMD_LOAD: begin
        goal_tab[it.step_slot]  = it.step_goal;
        reach_tab[it.step_slot] = it.reach_ticks;
        hold_tab[it.step_slot]  = it.hold_ticks;
        n_loads++;
      end
      CMD_ENABLE: prog_now = PS_INIT;
      CMD_DISABLE: prog_now = PS_DISABLE;
      default: begin
        n_ticks++;
        case (prog_now)
          PS_INIT: begin
            if (eff > 0) begin
              step_idx = '0;
              step_now = SS_INIT;
              prog_now = PS_WAIT;
            end else begin
              prog_now = PS_OFF;
            end
          end
          PS_WAIT: if (it.go_signal) prog_now = PS_SLAVE_EN;
          PS_SLAVE_EN: begin
            req = REQ_ENABLE;
            if (it.slave_confirms) prog_now = PS_RUN;
          end
          PS_RUN: begin
            goal  = goal_tab[step_idx];
            reach = reach_tab[step_idx];
            hold  = hold_tab[step_idx];
            case (step_now)
              SS_INIT: begin
                elapsed = '0;
                if (reach > 0) begin
                  if (!it.sensor_ok) begin
                    step_now = SS_FAIL;
                    n_step_fails++;
                  end else begin
                    ramp_base = it.sensor_value;
                    diff      = longint'(goal) - longint'(ramp_base);
                    ramp_rate = clamp_value(diff / longint'(reach));
                    step_now  = SS_RAMP;
                  end
                end else if (hold > 0) begin
                  step_now = SS_HOLD;
                end else begin
                  step_now = SS_DONE;
                end
              end
              SS_RAMP: begin
                if (elapsed >= reach) begin
                  elapsed  = '0;
                  step_now = (hold > 0) ? SS_HOLD : SS_DONE;
                end else begin
                  // elapsed * slope, magnitude capped at 2^VALUE_W
                  mag = (ramp_rate < 0) ? -longint'(ramp_rate) : longint'(ramp_rate);
                  e   = elapsed;
                  if (mag != 0 && e > cap / mag) pm = cap;
                  else pm = e * mag;
                  if (pm > cap) pm = cap;
                  prod = (ramp_rate < 0) ? -longint'(pm) : longint'(pm);
                  sp   = clamp_value(longint'(ramp_base) + prod);
                  send = 1'b1;
                  if (elapsed != '1) elapsed++;
                end
              end
              SS_HOLD: begin
                if (elapsed >= hold) begin
                  step_now = SS_DONE;
                end else begin
                  sp   = goal;
                  send = 1'b1;
                  if (elapsed != '1) elapsed++;
                end
              end
              default: ;
            endcase
            if (step_now == SS_DONE) prog_now = PS_NEXT;
            else if (step_now == SS_FAIL) prog_now = PS_DISABLE;
          end
          PS_NEXT: begin
            if (CNT_W'(step_idx) + 1 >= eff) begin
              prog_now = PS_DISABLE;
            end else begin
              step_idx = step_idx + 1'b1;
              step_now = SS_INIT;
              prog_now = PS_RUN;
            end
          end
          PS_DISABLE: begin
            req = REQ_DISABLE;
            if (it.slave_confirms) prog_now = PS_OFF;
          end
          default: prog_now = PS_OFF;
        endcase
      end
    endcase
    if (send) n_sends++;
    r.program_state = prog_now;
    r.step_state    = step_now;
    r.active_step   = step_idx;
    r.setpoint      = send ? sp : '0;
    r.setpoint_send = send;
    r.slave_request = req;
    return r;
  endfunction

  // Stimulus helpers
  function automatic in_item_t random_item();
    in_item_t it;
    it.command        = 2'($urandom_range(3));
    it.step_slot      = IDX_W'($urandom_range(MAX_STEPS - 1));
    it.step_goal      = $urandom;
    it.reach_ticks    = $urandom;
    it.hold_ticks     = $urandom;
    it.sensor_value   = $urandom;
    it.sensor_ok      = 1'($urandom_range(1));
    it.go_signal      = 1'($urandom_range(1));
    it.slave_confirms = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic void queue_raw(in_item_t it);
    if (it.command == CMD_LOAD) loaded[it.step_slot] = 1'b1;
    pending_items.push_back(it);
    n_queued++;
  endfunction

  function automatic void queue_load(logic [IDX_W-1:0] slot, logic signed [VALUE_W-1:0] goal,
                                     logic [TICK_W-1:0] reach, logic [TICK_W-1:0] hold);
    in_item_t it;
    it             = random_item();
    it.command     = CMD_LOAD;
    it.step_slot   = slot;
    it.step_goal   = goal;
    it.reach_ticks = reach;
    it.hold_ticks  = hold;
    queue_raw(it);
  endfunction

  function automatic void queue_tick(logic signed [VALUE_W-1:0] sensor, bit ok, bit go, bit conf);
    in_item_t it;
    it                = random_item();
    it.command        = CMD_TICK;
    it.sensor_value   = sensor;
    it.sensor_ok      = ok;
    it.go_signal      = go;
    it.slave_confirms = conf;
    queue_raw(it);
  endfunction

  function automatic void queue_command(cmd_e c);
    in_item_t it;
    it         = random_item();
    it.command = c;
    queue_raw(it);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return V_MAX;
      1: return V_MIN;
      2: return '0;
      3, 4, 5, 6: return $urandom;
      default: return $signed($urandom_range(1 << 21)) - (1 << 20);
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] pick_ticks();
    if ($urandom_range(15) == 0) return $urandom;
    return $urandom_range(5);
  endfunction

  // Length of the run of loaded slots starting at slot 0
  function automatic int loaded_prefix();
    int p;
    p = 0;
    while (p < MAX_STEPS && loaded[p]) p++;
    return p;
  endfunction

  // Wait until nothing is queued or in flight, plus the pipeline latency
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_step_count(logic [CNT_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_count_reg = value;
    n_cfg++;
    @(negedge clk);
  endtask

  // Sender: offers queued items, idles at random outside a steady window
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(next_programmer_result(in_item));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 &&
            ((n_accepted >= 250 && n_accepted < 330) || $urandom_range(99) >= 32)) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string tag, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("result %0d %s: expected %0h, got %0h", n_results, tag, want, got);
    end
  endfunction

  // Receiver: checks each result, stalls at random and once for a long stretch
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("result %0d arrived with none expected", n_results);
        end else begin
          want_item = expected_results.pop_front();
          check_field("program_state", want_item.program_state, out_item.program_state);
          check_field("step_state", want_item.step_state, out_item.step_state);
          check_field("active_step", want_item.active_step, out_item.active_step);
          check_field("setpoint", want_item.setpoint, out_item.setpoint);
          check_field("setpoint_send", want_item.setpoint_send, out_item.setpoint_send);
          check_field("slave_request", want_item.slave_request, out_item.slave_request);
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!held_once && n_results >= 100 && in_valid) begin
        held_once <= 1'b1;
        hold_left <= HOLD_OFF;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (n_results >= 250 && n_results < 330) || $urandom_range(99) >= 32;
      end
    end
  end

  // Watchdog on cycles without any accepted item or delivered result
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int                n;
    int                k;
    int                budget;
    int                seq;
    logic [TICK_W-1:0] r;
    logic [TICK_W-1:0] h;
    logic [CNT_W-1:0]  cnt;

    step_count_reg = '0;
    prog_now       = PS_OFF;
    step_now       = SS_INIT;
    step_idx       = '0;
    elapsed        = '0;
    ramp_base      = '0;
    ramp_rate      = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty program, then a three-step table
    write_step_count('0);
    queue_tick('0, 1'b1, 1'b1, 1'b1);
    queue_command(CMD_ENABLE);
    queue_tick('0, 1'b1, 1'b1, 1'b1);       // no steps: back to off
    queue_load(0, V_MAX, 32'd1, 32'd1);     // full-range ramp in one tick, slope saturates
    queue_load(1, V_MIN, 32'd0, 32'd2);     // no ramp
    queue_load(2, '0, 32'd0, 32'd0);        // neither ramp nor hold
    queue_load(MAX_STEPS - 1, 1, '1, '1);   // widest times
    write_step_count(3);
    queue_command(CMD_ENABLE);
    queue_tick(V_MAX, 1'b1, 1'b0, 1'b0);    // init -> wait for go
    queue_tick(V_MAX, 1'b1, 1'b0, 1'b1);    // no go yet
    queue_tick(V_MAX, 1'b1, 1'b1, 1'b0);    // -> slave enable
    queue_tick(V_MAX, 1'b1, 1'b1, 1'b0);    // unconfirmed: request repeats
    queue_tick(V_MAX, 1'b1, 1'b1, 1'b1);    // -> run
    queue_tick(V_MIN, 1'b1, 1'b1, 1'b1);    // ramp start from the lowest reading
    queue_tick('0, 1'b1, 1'b1, 1'b1);
    queue_tick('0, 1'b1, 1'b1, 1'b1);       // ramp over, into hold
    // count drops so that the running step is the last; the step finishes, then disable
    write_step_count(1);
    repeat (3) queue_tick('0, 1'b1, 1'b1, 1'b1);
    queue_tick('0, 1'b1, 1'b1, 1'b0);
    queue_tick('0, 1'b1, 1'b1, 1'b1);
    // sensor failure at ramp start
    queue_command(CMD_ENABLE);
    queue_tick('0, 1'b1, 1'b1, 1'b1);
    queue_tick('0, 1'b1, 1'b1, 1'b1);
    queue_tick('0, 1'b1, 1'b1, 1'b1);
    queue_tick(V_MAX, 1'b0, 1'b1, 1'b1);
    queue_command(CMD_DISABLE);
    queue_tick('0, 1'b1, 1'b1, 1'b1);

    // Random programs: load a table, set the count, enable, tick it through
    seq = 0;
    while (n_queued < 420) begin
      if (seq == 0) n = 6;
      else if (seq == 1 || $urandom_range(7) == 0) n = MAX_STEPS;
      else n = $urandom_range(1, 3);
      budget = 10;
      for (k = 0; k < n; k++) begin
        r = pick_ticks();
        h = pick_ticks();
        queue_load(IDX_W'(k), pick_value(), r, h);
        budget += ((r > 6) ? 6 : r) + ((h > 6) ? 6 : h) + 3;
      end
      if (seq == 1) cnt = '1;
      else if ($urandom_range(9) == 0) cnt = '0;
      else if (loaded_prefix() == MAX_STEPS && $urandom_range(3) == 0)
        cnt = CNT_W'($urandom_range(MAX_STEPS, (1 << CNT_W) - 1));
      else cnt = CNT_W'($urandom_range(1, n));
      write_step_count(cnt);
      queue_command(CMD_ENABLE);
      repeat (budget) begin
        if ($urandom_range(15) == 0) queue_raw(random_item());
        else queue_tick(pick_value(), $urandom_range(11) != 0, $urandom_range(4) != 0,
                        $urandom_range(4) != 0);
      end
      seq++;
    end

    wait_idle();
    $display("Covered %0d items: %0d loads, %0d ticks, %0d other commands, %0d count settings.",
             n_accepted, n_loads, n_ticks, n_accepted - n_loads - n_ticks, n_cfg);
    $display("Checked %0d results; %0d carried a setpoint, %0d steps failed on the sensor.",
             n_results, n_sends, n_step_fails);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rsp_pkg.sv
sv/rsp_div.sv
sv/rsp_dpath.sv
sv/rsp_ctrl.sv
sv/ramp_soak_setpoint_programmer_top.sv
sim/tb.sv
